// File: rtl/core/ami_pkg.sv
// Shared types and constants for the affine matrix inverse block.
package ami_pkg;

	localparam int N_ROWS   = 3;
	localparam int N_LIN    = 3;
	localparam int N_COLS   = 4;
	localparam int ROW_BITS = 2;
	localparam logic [ROW_BITS-1:0] ROW_FIRST = 2'd0;
	localparam logic [ROW_BITS-1:0] ROW_LAST  = 2'd2;

	// Sideband that travels with one result row
	typedef struct packed {
		logic [ROW_BITS-1:0] row_index;
		logic                singular;
		logic                last_row;
	} row_tag_t;

endpackage

// File: rtl/core/ami_divider.sv
// Pipelined four-lane restoring divider with sign, saturation and singular override, one quotient bit per stage.
module ami_divider #(
	parameter int WORD_BITS = 32,
	parameter int REM_BITS  = 132
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ami_pkg::row_tag_t           in_tag,
	input  logic [REM_BITS-1:0]         in_num [ami_pkg::N_COLS],
	input  logic [REM_BITS-1:0]         in_den,
	input  logic [ami_pkg::N_COLS-1:0]  in_neg,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ami_pkg::row_tag_t           out_tag,
	output logic signed [WORD_BITS-1:0] out_col [ami_pkg::N_COLS],
	output logic                        out_ovf
);

	localparam int W   = WORD_BITS;
	localparam int NC  = ami_pkg::N_COLS;
	localparam int LST = W + 1;
	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

	logic                    v_s   [0:LST];
	logic                    rdy   [0:LST];
	ami_pkg::row_tag_t       tag_s [0:LST];
	logic [REM_BITS-1:0]     rem_s [0:W][NC];
	logic [REM_BITS-1:0]     den_s [0:W];
	logic [W-1:0]            q_s   [0:W][NC];
	logic [NC-1:0]           big_s [0:W];
	logic [NC-1:0]           neg_s [0:W];
	logic signed [W-1:0]     col_s [NC];
	logic                    ovf_s;

	// bubble-collapsing ready chain
	assign rdy[LST] = !v_s[LST] || out_ready;
	for (genvar g = 0; g < LST; g++) begin : g_rdy
		assign rdy[g] = !v_s[g] || rdy[g+1];
	end
	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= LST; s++) v_s[s] <= 1'b0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int s = 1; s <= LST; s++)
				if (rdy[s]) v_s[s] <= v_s[s-1];
		end
	end

	always_ff @(posedge clk) begin
		logic ovf;
		logic any;
		// entry: range check, quotient of 2^W or more saturates
		if (rdy[0] && in_valid) begin
			tag_s[0] <= in_tag;
			den_s[0] <= in_den;
			neg_s[0] <= in_neg;
			for (int c = 0; c < NC; c++) begin
				rem_s[0][c] <= in_num[c];
				q_s[0][c]   <= '0;
				big_s[0][c] <= in_num[c] >= (in_den << W);
			end
		end
		// restoring steps, MSB first
		for (int s = 1; s <= W; s++) begin
			if (rdy[s] && v_s[s-1]) begin
				tag_s[s] <= tag_s[s-1];
				den_s[s] <= den_s[s-1];
				neg_s[s] <= neg_s[s-1];
				big_s[s] <= big_s[s-1];
				for (int c = 0; c < NC; c++) begin
					if (rem_s[s-1][c] >= (den_s[s-1] << (W - s))) begin
						rem_s[s][c] <= rem_s[s-1][c] - (den_s[s-1] << (W - s));
						q_s[s][c]   <= {q_s[s-1][c][W-2:0], 1'b1};
					end else begin
						rem_s[s][c] <= rem_s[s-1][c];
						q_s[s][c]   <= {q_s[s-1][c][W-2:0], 1'b0};
					end
				end
			end
		end
		// sign, saturation, singular override
		if (rdy[LST] && v_s[W]) begin
			tag_s[LST] <= tag_s[W];
			any = 1'b0;
			for (int c = 0; c < NC; c++) begin
				ovf = big_s[W][c] ||
					(neg_s[W][c] ? (q_s[W][c] > NEG_MAG) : (q_s[W][c] > POS_MAX));
				if (tag_s[W].singular)
					col_s[c] <= '0;
				else if (neg_s[W][c])
					col_s[c] <= ovf ? $signed(NEG_MAG) : $signed(-q_s[W][c]);
				else
					col_s[c] <= ovf ? $signed(POS_MAX) : $signed(q_s[W][c]);
				any = any | ovf;
			end
			ovf_s <= any && !tag_s[W].singular;
		end
	end

	assign out_valid = v_s[LST];
	assign out_tag   = tag_s[LST];
	assign out_col   = col_s;
	assign out_ovf   = ovf_s;

endmodule

// File: rtl/core/affine_matrix_inverse.sv
// Affine 3x4 matrix inverse: cofactor front end, row serialiser and divider pipeline.
// Row order: row 0 of a matrix leaves first, then rows 1 and 2 follow it.
// Throughput: one row beat every cycle while row_stall is low; the row
//   serialiser at stage 6 feeds all three rows of a matrix through one row path.
// Reset: arst_n clears every valid bit and the row counter; data registers keep
//   whatever they hold.
module affine_matrix_inverse #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               mat_valid,
	output logic                               mat_stall,
	input  logic signed [WORD_BITS-1:0]        m00,
	input  logic signed [WORD_BITS-1:0]        m01,
	input  logic signed [WORD_BITS-1:0]        m02,
	input  logic signed [WORD_BITS-1:0]        m03,
	input  logic signed [WORD_BITS-1:0]        m10,
	input  logic signed [WORD_BITS-1:0]        m11,
	input  logic signed [WORD_BITS-1:0]        m12,
	input  logic signed [WORD_BITS-1:0]        m13,
	input  logic signed [WORD_BITS-1:0]        m20,
	input  logic signed [WORD_BITS-1:0]        m21,
	input  logic signed [WORD_BITS-1:0]        m22,
	input  logic signed [WORD_BITS-1:0]        m23,
	output logic                               row_valid,
	input  logic                               row_stall,
	output logic [ami_pkg::ROW_BITS-1:0]       row_index,
	output logic signed [WORD_BITS-1:0]        col0,
	output logic signed [WORD_BITS-1:0]        col1,
	output logic signed [WORD_BITS-1:0]        col2,
	output logic signed [WORD_BITS-1:0]        col3,
	output logic                               singular,
	output logic                               overflowed,
	output logic                               last_row
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;          // plain product
	localparam int AW  = 2 * W + 1;      // cofactor
	localparam int PPW = 2 * W + 1;      // partial product, word by half cofactor
	localparam int CW  = 3 * W + 1;      // word by cofactor
	localparam int DW  = 3 * W + 3;      // determinant, translation sum
	localparam int NLW = AW + 2 * F;
	localparam int NTW = DW + 1 + F;
	localparam int NW  = (NLW > NTW) ? NLW : NTW;
	localparam int RW  = ((NW + 1) > (DW + 1 + W)) ? (NW + 1) : (DW + 1 + W);
	localparam int NC  = ami_pkg::N_COLS;
	localparam int NL  = ami_pkg::N_LIN;

	logic signed [W-1:0] m_in [3][4];

	assign m_in[0][0] = m00; assign m_in[0][1] = m01;
	assign m_in[0][2] = m02; assign m_in[0][3] = m03;
	assign m_in[1][0] = m10; assign m_in[1][1] = m11;
	assign m_in[1][2] = m12; assign m_in[1][3] = m13;
	assign m_in[2][0] = m20; assign m_in[2][1] = m21;
	assign m_in[2][2] = m22; assign m_in[2][3] = m23;

	// ---------------------------------------------------------------
	// Handshake: each stage but stage 6 loads when empty or when its successor loads
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic rdy_s7, rdy_s8, rdy_s9, rdy_s10, rdy_s11, rdy_s12;
	logic div_ready;
	logic [ami_pkg::ROW_BITS-1:0] row_q;
	logic row_done;

	assign row_done = (row_q == ami_pkg::ROW_LAST);

	assign rdy_s12 = !v_s12 || div_ready;
	assign rdy_s11 = !v_s11 || rdy_s12;
	assign rdy_s10 = !v_s10 || rdy_s11;
	assign rdy_s9  = !v_s9  || rdy_s10;
	assign rdy_s8  = !v_s8  || rdy_s9;
	assign rdy_s7  = !v_s7  || rdy_s8;
	// stage 6 holds the matrix until its last row has gone down the row path
	assign rdy_s6  = !v_s6  || (rdy_s7 && row_done);
	assign rdy_s5  = !v_s5  || rdy_s6;
	assign rdy_s4  = !v_s4  || rdy_s5;
	assign rdy_s3  = !v_s3  || rdy_s4;
	assign rdy_s2  = !v_s2  || rdy_s3;
	assign rdy_s1  = !v_s1  || rdy_s2;

	assign mat_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			row_q <= ami_pkg::ROW_FIRST;
		end else begin
			if (rdy_s1)  v_s1  <= mat_valid;
			if (rdy_s2)  v_s2  <= v_s1;
			if (rdy_s3)  v_s3  <= v_s2;
			if (rdy_s4)  v_s4  <= v_s3;
			if (rdy_s5)  v_s5  <= v_s4;
			if (rdy_s6)  v_s6  <= v_s5;
			if (rdy_s7)  v_s7  <= v_s6;
			if (rdy_s8)  v_s8  <= v_s7;
			if (rdy_s9)  v_s9  <= v_s8;
			if (rdy_s10) v_s10 <= v_s9;
			if (rdy_s11) v_s11 <= v_s10;
			if (rdy_s12) v_s12 <= v_s11;
			// row counter steps on every row beat leaving stage 6
			if (v_s6 && rdy_s7) begin
				if (row_done) row_q <= ami_pkg::ROW_FIRST;
				else          row_q <= row_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Matrix front end
	// ---------------------------------------------------------------
	logic signed [W-1:0]   m_s1 [3][4];
	logic signed [W-1:0]   m_s2 [3][4];
	logic signed [W-1:0]   m_s3 [3][4];
	logic signed [PW-1:0]  pa_s2 [3][3];
	logic signed [PW-1:0]  pb_s2 [3][3];
	logic signed [AW-1:0]  adj_s3 [3][3];
	logic signed [AW-1:0]  adj_s4 [3][3];
	logic signed [AW-1:0]  adj_s5 [3][3];
	logic signed [AW-1:0]  adj_s6 [3][3];
	logic signed [PPW-1:0] dhi_s4 [NL];
	logic signed [PPW-1:0] dlo_s4 [NL];
	logic signed [CW-1:0]  dp_s5 [NL];
	logic signed [DW-1:0]  det_s6;
	logic signed [W-1:0]   c3_s4 [NL];
	logic signed [W-1:0]   c3_s5 [NL];
	logic signed [W-1:0]   c3_s6 [NL];

	// s1: matrix register
	always_ff @(posedge clk) begin
		if (rdy_s1 && mat_valid) m_s1 <= m_in;
	end

	// s2: the eighteen cofactor products
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			m_s2 <= m_s1;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					pa_s2[i][j] <= m_s1[(j+1)%3][(i+1)%3] * m_s1[(j+2)%3][(i+2)%3];
					pb_s2[i][j] <= m_s1[(j+1)%3][(i+2)%3] * m_s1[(j+2)%3][(i+1)%3];
				end
		end
	end

	// s3: adjugate
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			m_s3 <= m_s2;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					adj_s3[i][j] <= AW'(pa_s2[i][j]) - AW'(pb_s2[i][j]);
		end
	end

	// s4: determinant terms, cofactor split into signed high and unsigned low halves
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			adj_s4 <= adj_s3;
			for (int j = 0; j < NL; j++) begin
				c3_s4[j]  <= m_s3[j][3];
				dhi_s4[j] <= m_s3[0][j] * $signed(adj_s3[j][0][AW-1:W]);
				dlo_s4[j] <= m_s3[0][j] * $signed({1'b0, adj_s3[j][0][W-1:0]});
			end
		end
	end

	// s5: recombine halves
	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			adj_s5 <= adj_s4;
			c3_s5  <= c3_s4;
			for (int j = 0; j < NL; j++)
				dp_s5[j] <= (CW'(dhi_s4[j]) <<< W) + CW'(dlo_s4[j]);
		end
	end

	// s6: determinant; held here while the rows are sent out
	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			adj_s6 <= adj_s5;
			c3_s6  <= c3_s5;
			det_s6 <= DW'(dp_s5[0]) + DW'(dp_s5[1]) + DW'(dp_s5[2]);
		end
	end

	// ---------------------------------------------------------------
	// Row path
	// ---------------------------------------------------------------
	logic signed [AW-1:0]  sel_adj [NL];
	logic signed [PPW-1:0] thi_s7 [NL];
	logic signed [PPW-1:0] tlo_s7 [NL];
	logic signed [AW-1:0]  adj_s7 [NL];
	logic signed [AW-1:0]  adj_s8 [NL];
	logic signed [AW-1:0]  adj_s9 [NL];
	logic signed [DW-1:0]  det_s7, det_s8, det_s9;
	logic signed [CW-1:0]  tp_s8 [NL];
	logic signed [DW-1:0]  t_s9;
	logic signed [NW-1:0]  num_s10 [NC];
	logic [DW-1:0]         adet_s10, adet_s11;
	logic                  dneg_s10;
	logic [NW-1:0]         mag_s11 [NC];
	logic [NC-1:0]         neg_s11, neg_s12;
	logic [RW-1:0]         nn_s12 [NC];
	logic [RW-1:0]         dd_s12;
	ami_pkg::row_tag_t     tag_s7, tag_s8, tag_s9, tag_s10, tag_s11, tag_s12;

	always_comb begin
		case (row_q)
			2'd0:    sel_adj = adj_s6[0];
			2'd1:    sel_adj = adj_s6[1];
			2'd2:    sel_adj = adj_s6[2];
			default: sel_adj = adj_s6[0];
		endcase
	end

	// s7: translation terms for the selected row
	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			adj_s7 <= sel_adj;
			det_s7 <= det_s6;
			tag_s7.row_index <= row_q;
			tag_s7.singular  <= (det_s6 == '0);
			tag_s7.last_row  <= row_done;
			for (int j = 0; j < NL; j++) begin
				thi_s7[j] <= c3_s6[j] * $signed(sel_adj[j][AW-1:W]);
				tlo_s7[j] <= c3_s6[j] * $signed({1'b0, sel_adj[j][W-1:0]});
			end
		end
	end

	// s8: recombine
	always_ff @(posedge clk) begin
		if (rdy_s8 && v_s7) begin
			adj_s8 <= adj_s7;
			det_s8 <= det_s7;
			tag_s8 <= tag_s7;
			for (int j = 0; j < NL; j++)
				tp_s8[j] <= (CW'(thi_s7[j]) <<< W) + CW'(tlo_s7[j]);
		end
	end

	// s9: adj row dotted with the old translation
	always_ff @(posedge clk) begin
		if (rdy_s9 && v_s8) begin
			adj_s9 <= adj_s8;
			det_s9 <= det_s8;
			tag_s9 <= tag_s8;
			t_s9   <= DW'(tp_s8[0]) + DW'(tp_s8[1]) + DW'(tp_s8[2]);
		end
	end

	// s10: scaled numerators, determinant magnitude
	always_ff @(posedge clk) begin
		if (rdy_s10 && v_s9) begin
			tag_s10  <= tag_s9;
			dneg_s10 <= det_s9[DW-1];
			adet_s10 <= det_s9[DW-1] ? DW'(-det_s9) : DW'(det_s9);
			for (int j = 0; j < NL; j++)
				num_s10[j] <= NW'(adj_s9[j]) <<< (2 * F);
			num_s10[NL] <= (-NW'(t_s9)) <<< F;
		end
	end

	// s11: numerator magnitudes and quotient signs
	always_ff @(posedge clk) begin
		if (rdy_s11 && v_s10) begin
			tag_s11  <= tag_s10;
			adet_s11 <= adet_s10;
			for (int c = 0; c < NC; c++) begin
				mag_s11[c] <= num_s10[c][NW-1] ? NW'(-num_s10[c]) : NW'(num_s10[c]);
				neg_s11[c] <= num_s10[c][NW-1] ^ dneg_s10;
			end
		end
	end

	// s12: round to nearest, ties away: floor((2|n| + |d|) / 2|d|)
	always_ff @(posedge clk) begin
		if (rdy_s12 && v_s11) begin
			tag_s12 <= tag_s11;
			neg_s12 <= neg_s11;
			dd_s12  <= RW'(adet_s11) << 1;
			for (int c = 0; c < NC; c++)
				nn_s12[c] <= (RW'(mag_s11[c]) << 1) + RW'(adet_s11);
		end
	end

	// ---------------------------------------------------------------
	// Divider and output register
	// ---------------------------------------------------------------
	ami_pkg::row_tag_t     res_tag;
	logic signed [W-1:0]   res_col [NC];

	ami_divider #(
		.WORD_BITS (W),
		.REM_BITS  (RW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s12),
		.in_ready  (div_ready),
		.in_tag    (tag_s12),
		.in_num    (nn_s12),
		.in_den    (dd_s12),
		.in_neg    (neg_s12),
		.out_valid (row_valid),
		.out_ready (!row_stall),
		.out_tag   (res_tag),
		.out_col   (res_col),
		.out_ovf   (overflowed)
	);

	assign row_index = res_tag.row_index;
	assign singular  = res_tag.singular;
	assign last_row  = res_tag.last_row;
	assign col0      = res_col[0];
	assign col1      = res_col[1];
	assign col2      = res_col[2];
	assign col3      = res_col[3];

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && singular |-> col0 == '0 && col1 == '0 && col2 == '0 &&
			col3 == '0 && !overflowed)
		else $error("singular row carries non-zero entries");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> last_row == (row_index == ami_pkg::ROW_LAST))
		else $error("last_row flag disagrees with row index");

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != ami_pkg::ROW_FIRST |-> v_s6)
		else $error("row counter mid-matrix with no matrix held");

endmodule

// File: test/affine_matrix_inverse_tb.sv
// Testbench for the affine 3x4 matrix inverse: directed and random matrices, checked row by row.
`timescale 1ns / 100ps

module affine_matrix_inverse_tb;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam logic signed [WB-1:0] ONE   = 32'sh0001_0000;
	localparam logic signed [WB-1:0] W_MAX = 32'sh7fff_ffff;
	localparam logic signed [WB-1:0] W_MIN = 32'sh8000_0000;

	// One expected row of the inverse
	typedef struct {
		logic [ami_pkg::ROW_BITS-1:0] idx;
		logic signed [WB-1:0]         c [ami_pkg::N_COLS];
		logic                         sing;
		logic                         ovf;
		logic                         last;
	} inv_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	logic signed [WB-1:0] m [ami_pkg::N_ROWS][ami_pkg::N_COLS];
	logic row_valid;
	logic row_stall = 1'b0;
	logic [ami_pkg::ROW_BITS-1:0] row_index;
	logic signed [WB-1:0] col0, col1, col2, col3;
	logic singular, overflowed, last_row;

	inv_row_t expected_rows[$];
	int  n_errors = 0;
	int  n_mats   = 0;
	int  n_rows   = 0;
	int  n_sing   = 0;
	int  n_sat    = 0;
	bit  quiet    = 1'b0;	// no idling on either side for the closing stretch

	always #5 clk = ~clk;

	initial begin
		foreach (m[i, j]) m[i][j] = '0;
	end

	affine_matrix_inverse #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall),
		.m00(m[0][0]), .m01(m[0][1]), .m02(m[0][2]), .m03(m[0][3]),
		.m10(m[1][0]), .m11(m[1][1]), .m12(m[1][2]), .m13(m[1][3]),
		.m20(m[2][0]), .m21(m[2][1]), .m22(m[2][2]), .m23(m[2][3]),
		.row_valid(row_valid), .row_stall(row_stall),
		.row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3),
		.singular(singular), .overflowed(overflowed), .last_row(last_row)
	);

	// round(num/den), ties away from zero, saturated to a signed word.
	// Products are at most ~2^98 and shifted numerators ~2^112, so 256 bits is plenty.
	function automatic logic signed [WB-1:0] round_div_sat(
		input logic signed [255:0] num, input logic signed [255:0] den, inout logic ovf);
		logic        neg;
		logic [255:0] an, ad, q;
		neg = (num < 0) != (den < 0);
		an  = (num < 0) ? -num : num;
		ad  = (den < 0) ? -den : den;
		q   = (2 * an + ad) / (2 * ad);
		if (!neg) begin
			if (q > 256'h7fff_ffff) begin
				ovf = 1'b1;
				return W_MAX;
			end
			return q[WB-1:0];
		end
		if (q > 256'h8000_0000) begin
			ovf = 1'b1;
			return W_MIN;
		end
		return -q[WB-1:0];
	endfunction

	// Inverse of [L | t] by cofactors: L^-1 = adj(L)/det, t' = -L^-1 t
	task automatic predict_inverse(
		input logic signed [WB-1:0] a [ami_pkg::N_ROWS][ami_pkg::N_COLS]);
		logic signed [255:0] x [ami_pkg::N_ROWS][ami_pkg::N_COLS];
		logic signed [255:0] adj [ami_pkg::N_LIN][ami_pkg::N_LIN];
		logic signed [255:0] det, t;
		inv_row_t r;
		int i1, i2, j1, j2;
		foreach (a[i, j]) x[i][j] = a[i][j];
		for (int i = 0; i < ami_pkg::N_LIN; i++)
			for (int j = 0; j < ami_pkg::N_LIN; j++) begin
				j1 = (j + 1) % 3; j2 = (j + 2) % 3;
				i1 = (i + 1) % 3; i2 = (i + 2) % 3;
				adj[i][j] = x[j1][i1] * x[j2][i2] - x[j1][i2] * x[j2][i1];
			end
		det = x[0][0] * adj[0][0] + x[0][1] * adj[1][0] + x[0][2] * adj[2][0];
		if (det == 0) n_sing++;
		for (int i = 0; i < ami_pkg::N_ROWS; i++) begin
			r.idx  = i[ami_pkg::ROW_BITS-1:0];
			r.sing = (det == 0);
			r.ovf  = 1'b0;
			r.last = (i == ami_pkg::N_ROWS - 1);
			foreach (r.c[k]) r.c[k] = '0;
			if (det != 0) begin
				t = 0;
				for (int j = 0; j < ami_pkg::N_LIN; j++) begin
					r.c[j] = round_div_sat(adj[i][j] <<< (2 * FB), det, r.ovf);
					t += adj[i][j] * x[j][3];
				end
				r.c[3] = round_div_sat((-t) <<< FB, det, r.ovf);
			end
			if (r.ovf) n_sat++;
			expected_rows.push_back(r);
		end
	endtask

	// Sends one matrix beat; at random idles a random burst beforehand unless quiet.
	// Valid stays high between back-to-back beats and drops in idles and drain.
	task automatic send_matrix(input logic signed [WB-1:0] a [ami_pkg::N_ROWS][ami_pkg::N_COLS]);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			mat_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		m = a;
		mat_valid <= 1'b1;
		@(posedge clk);
		while (mat_stall) @(posedge clk);
		predict_inverse(a);
		n_mats++;
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, then stretches of no stall
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				row_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				row_stall <= 1'b0;
			end
		end
	end

	// Checks every accepted row against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && row_valid && !row_stall) begin
			inv_row_t e;
			n_rows++;
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected row, index %0d", $time, row_index);
				n_errors++;
			end else begin
				e = expected_rows.pop_front();
				if ({row_index, singular, overflowed, last_row} !== {e.idx, e.sing, e.ovf, e.last}
						|| col0 !== e.c[0] || col1 !== e.c[1]
						|| col2 !== e.c[2] || col3 !== e.c[3]) begin
					$display("%0t: mismatch expected idx %0d cols %h %h %h %h s%b o%b l%b",
						$time, e.idx, e.c[0], e.c[1], e.c[2], e.c[3], e.sing, e.ovf, e.last);
					$display("%0t:            actual idx %0d cols %h %h %h %h s%b o%b l%b",
						$time, row_index, col0, col1, col2, col3,
						singular, overflowed, last_row);
					n_errors++;
				end
			end
		end
	end

	function automatic logic signed [WB-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			2: return $signed($urandom_range(0, 255)) - 128;
			3: return $urandom_range(0, 1) ? W_MAX : W_MIN;
			default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	task automatic drain();
		mat_valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [WB-1:0] a [ami_pkg::N_ROWS][ami_pkg::N_COLS];
		// identity with translation
		foreach (a[i, j]) a[i][j] = (i == j) ? ONE : '0;
		a[0][3] = 3 * ONE; a[1][3] = -5 * ONE; a[2][3] = ONE / 2;
		send_matrix(a);
		// all zero: singular
		foreach (a[i, j]) a[i][j] = '0;
		send_matrix(a);
		// two equal rows: singular with nonzero entries
		foreach (a[i, j]) a[i][j] = (i + 1) * ONE + j;
		a[1] = a[0];
		send_matrix(a);
		// tiny diagonal: inverse saturates high
		foreach (a[i, j]) a[i][j] = (i == j) ? 32'sd1 : '0;
		send_matrix(a);
		// negative tiny diagonal with huge translation
		foreach (a[i, j]) a[i][j] = (i == j) ? -32'sd1 : '0;
		a[0][3] = W_MAX; a[1][3] = W_MIN; a[2][3] = W_MAX;
		send_matrix(a);
		// all extremes
		foreach (a[i, j]) a[i][j] = W_MIN;
		a[0][0] = W_MAX; a[1][1] = W_MAX; a[2][2] = -1;
		send_matrix(a);
		foreach (a[i, j]) a[i][j] = (i == j) ? W_MIN : W_MAX;
		send_matrix(a);
		// scale by two: exact halves; scale by three: rounding
		foreach (a[i, j]) a[i][j] = (i == j) ? 2 * ONE : '0;
		a[2][3] = -7;
		send_matrix(a);
		foreach (a[i, j]) a[i][j] = (i == j) ? 3 * ONE : '0;
		a[0][3] = 1; a[1][3] = -1; a[2][3] = 2;
		send_matrix(a);
		// det 2, with adj[0][0] and the row 0 translation odd
		foreach (a[i, j]) a[i][j] = '0;
		a[0][0] = 2; a[1][1] = 1; a[2][2] = 1; a[0][3] = -3;
		send_matrix(a);
		// permutation
		foreach (a[i, j]) a[i][j] = '0;
		a[0][1] = ONE; a[1][2] = -ONE; a[2][0] = ONE; a[1][3] = W_MAX;
		send_matrix(a);
		// sender waits for every row before going on
		drain();
	endtask

	task automatic test_random(input int count);
		logic signed [WB-1:0] a [ami_pkg::N_ROWS][ami_pkg::N_COLS];
		for (int n = 0; n < count; n++) begin
			foreach (a[i, j]) a[i][j] = rand_word();
			// one in eight forced singular by copying a row or zeroing a column
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1)) a[2][0:2] = a[$urandom_range(0, 1)][0:2];
				else foreach (a[i]) a[i][1] = '0;
			end
			send_matrix(a);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(380);
		quiet = 1'b1;		// closing stretch runs at full rate
		test_random(60);
		drain();
		$display("Covered %0d matrices, %0d rows; %0d singular, %0d rows saturated.",
			n_mats, n_rows, n_sing, n_sat);
		if (n_errors == 0 && expected_rows.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: affine_matrix_inverse.f
rtl/core/ami_pkg.sv
rtl/core/ami_divider.sv
rtl/core/affine_matrix_inverse.sv
test/affine_matrix_inverse_tb.sv
